/* sv/chd_pkg.sv */
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types and constants for the canonical Huffman decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_DECODE = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam int SYM_W   = 9;
   localparam int LEN_W   = 6;
   localparam int BYTE_W  = 8;
   localparam int TAB_W   = SYM_W + LEN_W;
   localparam logic [3:0] BYTE_BITS = 4'd8;
   localparam logic [3:0] LAST_BIT  = 4'd7;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_DECODE,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [SYM_W-1:0]    sym;
      logic [LEN_W-1:0]    len;
      logic [BYTE_W-1:0]   data;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_CNT,
      ST_LD_CMP,
      ST_LD_PUT,
      ST_DEC_RD,
      ST_DEC_EV,
      ST_DEC_SYM,
      ST_DEC_END
   } state_type;

endpackage

/* sv/chd_ram.sv */
// ----------------------------------------------------------------------------
// chd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* sv/chd_front.sv */
// ----------------------------------------------------------------------------
// chd_front
// Takes items, classifies them and queues them for the engine (2 deep).
// ----------------------------------------------------------------------------
module chd_front
   import chd_pkg::*;
#(
   parameter int MAX_CODE_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [SYM_W-1:0]  req_entry_symbol,
   input  logic [LEN_W-1:0]  req_entry_length,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              pop,
   output logic              q_valid,
   output item_type          q_item
);

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       keep;
   item_type   item;

   // drop unused codes and loads with a length outside 1..max
   always_comb begin
      item.sym  = req_entry_symbol;
      item.len  = req_entry_length;
      item.data = req_data_byte;
      item.op   = OP_LOAD;
      keep      = 1'b0;
      case (req_func)
         FUNC_LOAD: begin
            item.op = OP_LOAD;
            keep    = (req_entry_length != '0) &&
                      (int'(req_entry_length) <= MAX_CODE_LEN);
         end
         FUNC_DECODE: begin
            item.op = OP_DECODE;
            keep    = 1'b1;
         end
         FUNC_CLEAR: begin
            item.op = OP_CLEAR;
            keep    = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign busy    = (fill_ff == 2'd2);
   assign push    = start && !busy && keep;
   assign q_valid = (fill_ff != 2'd0);
   assign q_item  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ (pop && q_valid);
      fill_in = fill_ff + 2'(push) - 2'(pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= item;
      end
   end

endmodule

/* sv/chd_back.sv */
// ----------------------------------------------------------------------------
// chd_back
// Table insert engine and bit-serial canonical decode engine.
// ----------------------------------------------------------------------------
module chd_back
   import chd_pkg::*;
#(
   parameter int NUM_SYMBOLS  = 257,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  item_type          q_item,
   output logic              pop,
   output logic              rsp_valid,
   output logic [7:0]        rsp_symbol,
   output logic              rsp_end_of_data,
   output logic              rsp_code_error,
   output logic              rsp_last
);

   localparam int AW  = $clog2(NUM_SYMBOLS);
   localparam int IW  = $clog2(NUM_SYMBOLS + 1);
   localparam int RW  = $clog2(MAX_CODE_LEN + 1);
   localparam int CW  = (MAX_CODE_LEN + IW + 1 > 64) ? 64 : MAX_CODE_LEN + IW + 1;
   localparam int CD  = MAX_CODE_LEN + 1;
   localparam logic [IW-1:0] FULL  = IW'(NUM_SYMBOLS);
   localparam logic [RW-1:0] ROW_MAX = RW'(MAX_CODE_LEN);

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   logic [AW-1:0]    ins_ff, ins_in;
   logic [IW-1:0]    count_ff, count_in;
   logic [CD-1:0]    cvalid_ff, cvalid_in;
   logic [CW-1:0]    acc_ff, acc_in;
   logic [CW-1:0]    fc_ff, fc_in;
   logic [IW-1:0]    fi_ff, fi_in;
   logic [RW-1:0]    row_ff, row_in;
   logic             done_ff, done_in;
   logic [7:0]       byte_ff, byte_in;
   logic [3:0]       bcnt_ff, bcnt_in;
   logic             pend_ff, pend_in;
   logic [7:0]       psym_ff, psym_in;
   logic             pend_end_ff, pend_end_in;
   logic             pend_err_ff, pend_err_in;
   logic             rv_ff, rv_in;
   logic [7:0]       rsym_ff, rsym_in;
   logic             rend_ff, rend_in;
   logic             rerr_ff, rerr_in;
   logic             rlast_ff, rlast_in;

   logic             tab_we;
   logic [AW-1:0]    tab_waddr, tab_raddr;
   logic [TAB_W-1:0] tab_wdata, tab_q;
   logic             cnt_we;
   logic [RW-1:0]    cnt_waddr, cnt_raddr;
   logic [IW-1:0]    cnt_wdata, cnt_q;

   // decode step and insert compare datapath
   logic [RW-1:0]    row_nx;
   logic [IW-1:0]    cnt_w;
   logic [CW-1:0]    code_w, fc_w, diff_w;
   logic             match, idx_ok, row_end, byte_last;
   logic [IW-1:0]    idx_w;
   logic [SYM_W-1:0] q_sym;
   logic [LEN_W-1:0] q_len;
   logic             q_less, q_is_end;
   logic [IW-1:0]    lcnt;

   assign row_nx    = row_ff + RW'(1);
   assign cnt_w     = cvalid_ff[row_nx] ? cnt_q : '0;
   assign code_w    = acc_ff | CW'(byte_ff[7]);
   assign fc_w      = fc_ff << 1;
   assign diff_w    = code_w - fc_w;
   assign match     = (code_w >= fc_w) && (diff_w < CW'(cnt_w));
   assign idx_w     = fi_ff + diff_w[IW-1:0];
   assign idx_ok    = idx_w < count_ff;
   assign row_end   = row_nx >= ROW_MAX;
   assign byte_last = (bcnt_ff == LAST_BIT);

   assign q_sym    = tab_q[TAB_W-1:LEN_W];
   assign q_len    = tab_q[LEN_W-1:0];
   assign q_less   = (q_len < item_ff.len) ||
                     ((q_len == item_ff.len) && (q_sym < item_ff.sym));
   assign q_is_end = (32'(q_sym) == 32'(NUM_SYMBOLS - 1));
   assign lcnt     = cvalid_ff[item_ff.len[RW-1:0]] ? cnt_q : '0;

   chd_ram #(.WIDTH(TAB_W), .DEPTH(NUM_SYMBOLS)) u_tab (
      .clock (clock),
      .we    (tab_we),
      .waddr (tab_waddr),
      .wdata (tab_wdata),
      .raddr (tab_raddr),
      .rdata (tab_q)
   );

   chd_ram #(.WIDTH(IW), .DEPTH(CD)) u_cnt (
      .clock (clock),
      .we    (cnt_we),
      .waddr (cnt_waddr),
      .wdata (cnt_wdata),
      .raddr (cnt_raddr),
      .rdata (cnt_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_item.op)
                  OP_LOAD:   state_in = (count_ff == FULL) ? ST_IDLE : ST_LD_CNT;
                  OP_DECODE: state_in = done_ff ? ST_IDLE : ST_DEC_RD;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_LD_CNT: state_in = (count_ff == '0) ? ST_LD_PUT : ST_LD_CMP;
         ST_LD_CMP: begin
            if (q_less) begin
               state_in = ST_IDLE;
            end else if (ins_ff == AW'(1)) begin
               state_in = ST_LD_PUT;
            end else begin
               state_in = ST_LD_CMP;
            end
         end
         ST_LD_PUT: state_in = ST_IDLE;
         ST_DEC_RD: state_in = ST_DEC_EV;
         ST_DEC_EV: begin
            if (match && idx_ok) begin
               state_in = ST_DEC_SYM;
            end else if ((!match && row_end) || byte_last) begin
               state_in = ST_DEC_END;
            end else begin
               state_in = ST_DEC_RD;
            end
         end
         ST_DEC_SYM: state_in = (q_is_end || bcnt_ff == BYTE_BITS) ? ST_DEC_END : ST_DEC_RD;
         ST_DEC_END: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic       new_v;
      logic [7:0] new_sym;
      logic       new_end;
      logic       new_err;
      logic       flush;
      logic       restart;

      new_v   = 1'b0;
      new_sym = '0;
      new_end = 1'b0;
      new_err = 1'b0;
      flush   = 1'b0;
      restart = 1'b0;

      pop         = 1'b0;
      item_in     = item_ff;
      ins_in      = ins_ff;
      count_in    = count_ff;
      cvalid_in   = cvalid_ff;
      acc_in      = acc_ff;
      fc_in       = fc_ff;
      fi_in       = fi_ff;
      row_in      = row_ff;
      done_in     = done_ff;
      byte_in     = byte_ff;
      bcnt_in     = bcnt_ff;
      pend_in     = pend_ff;
      psym_in     = psym_ff;
      pend_end_in = pend_end_ff;
      pend_err_in = pend_err_ff;
      rv_in       = 1'b0;
      rsym_in     = rsym_ff;
      rend_in     = rend_ff;
      rerr_in     = rerr_ff;
      rlast_in    = rlast_ff;

      tab_we    = 1'b0;
      tab_waddr = ins_ff;
      tab_wdata = {item_ff.sym, item_ff.len};
      tab_raddr = ins_ff - AW'(1);
      cnt_we    = 1'b0;
      cnt_waddr = item_ff.len[RW-1:0];
      cnt_wdata = lcnt + IW'(1);
      cnt_raddr = row_nx;

      case (state_ff)
         ST_IDLE: begin
            pop       = q_valid;
            item_in   = q_item;
            cnt_raddr = q_item.len[RW-1:0];
            byte_in   = q_item.data;
            bcnt_in   = '0;
            if (q_valid && q_item.op == OP_CLEAR) begin
               count_in  = '0;
               cvalid_in = '0;
               done_in   = 1'b0;
               restart   = 1'b1;
            end
         end
         ST_LD_CNT: begin
            cnt_we    = 1'b1;
            cvalid_in[item_ff.len[RW-1:0]] = 1'b1;
            ins_in    = count_ff[AW-1:0];
            tab_raddr = count_ff[AW-1:0] - AW'(1);
         end
         ST_LD_CMP: begin
            tab_we = 1'b1;
            if (q_less) begin
               count_in = count_ff + IW'(1);
            end else begin
               tab_wdata = tab_q;
               ins_in    = ins_ff - AW'(1);
               tab_raddr = ins_ff - AW'(2);
            end
         end
         ST_LD_PUT: begin
            tab_we   = 1'b1;
            count_in = count_ff + IW'(1);
         end
         ST_DEC_EV: begin
            tab_raddr = idx_w[AW-1:0];
            byte_in   = byte_ff << 1;
            bcnt_in   = bcnt_ff + 4'd1;
            if (match) begin
               restart = 1'b1;
               if (!idx_ok) begin
                  new_v = 1'b1;
               end
            end else if (row_end) begin
               new_v   = 1'b1;
               new_err = 1'b1;
               done_in = 1'b1;
               restart = 1'b1;
            end else begin
               fc_in  = fc_w + CW'(cnt_w);
               fi_in  = fi_ff + cnt_w;
               acc_in = code_w << 1;
               row_in = row_nx;
            end
         end
         ST_DEC_SYM: begin
            new_v = 1'b1;
            if (q_is_end) begin
               new_end = 1'b1;
               done_in = 1'b1;
            end else begin
               new_sym = q_sym[7:0];
            end
         end
         ST_DEC_END: begin
            flush = 1'b1;
         end
         default: begin
         end
      endcase

      if (restart) begin
         acc_in = '0;
         fc_in  = '0;
         fi_in  = '0;
         row_in = '0;
      end

      // one result is held back so the final one of a byte can carry last
      if (new_v) begin
         if (pend_ff) begin
            rv_in    = 1'b1;
            rsym_in  = psym_ff;
            rend_in  = pend_end_ff;
            rerr_in  = pend_err_ff;
            rlast_in = 1'b0;
         end
         pend_in     = 1'b1;
         psym_in     = new_sym;
         pend_end_in = new_end;
         pend_err_in = new_err;
      end else if (flush) begin
         rv_in    = pend_ff;
         rsym_in  = psym_ff;
         rend_in  = pend_end_ff;
         rerr_in  = pend_err_ff;
         rlast_in = 1'b1;
         pend_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         cvalid_ff <= '0;
         acc_ff    <= '0;
         fc_ff     <= '0;
         fi_ff     <= '0;
         row_ff    <= '0;
         done_ff   <= 1'b0;
         pend_ff   <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cvalid_ff <= cvalid_in;
         acc_ff    <= acc_in;
         fc_ff     <= fc_in;
         fi_ff     <= fi_in;
         row_ff    <= row_in;
         done_ff   <= done_in;
         pend_ff   <= pend_in;
         rv_ff     <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      ins_ff      <= ins_in;
      byte_ff     <= byte_in;
      bcnt_ff     <= bcnt_in;
      psym_ff     <= psym_in;
      pend_end_ff <= pend_end_in;
      pend_err_ff <= pend_err_in;
      rsym_ff     <= rsym_in;
      rend_ff     <= rend_in;
      rerr_ff     <= rerr_in;
      rlast_ff    <= rlast_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_symbol      = rsym_ff;
   assign rsp_end_of_data = rend_ff;
   assign rsp_code_error  = rerr_ff;
   assign rsp_last        = rlast_ff;

endmodule

/* sv/canonical_huffman_decoder.sv */
// ----------------------------------------------------------------------------
// canonical_huffman_decoder
// Loadable canonical Huffman table with a bit-serial byte decoder.
// ----------------------------------------------------------------------------
//
//  channel   ports                          handshake
//  -------   -----------------------------  ------------------------------
//  request   req_func/entry_*/data_byte     taken when start && !busy
//  response  rsp_symbol/end/error/last      one-cycle strobe on rsp_valid
//
// A decode byte takes a dispatch step, a count read and an evaluate step per
// bit, a table read per matched symbol and a closing step; the shared count
// RAM read sets the pace. A load reads the count, shifts each larger table
// entry up one place and writes the new one. Clear acts at dispatch.
// Reset clears counts and decoder state; the table RAM holds no reset.
// busy rises when the 2-item queue is full; results cannot be held off.
//
module canonical_huffman_decoder
   import chd_pkg::*;
#(
   parameter int NUM_SYMBOLS  = 257,
   parameter int MAX_CODE_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_func,
   input  logic [SYM_W-1:0]  req_entry_symbol,
   input  logic [LEN_W-1:0]  req_entry_length,
   input  logic [BYTE_W-1:0] req_data_byte,
   output logic              rsp_valid,
   output logic [7:0]        rsp_symbol,
   output logic              rsp_end_of_data,
   output logic              rsp_code_error,
   output logic              rsp_last
);

   logic     q_valid;
   logic     pop;
   item_type q_item;

   // front: classify and queue items
   chd_front #(.MAX_CODE_LEN(MAX_CODE_LEN)) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_entry_symbol (req_entry_symbol),
      .req_entry_length (req_entry_length),
      .req_data_byte    (req_data_byte),
      .pop              (pop),
      .q_valid          (q_valid),
      .q_item           (q_item)
   );

   // back: table insert and decode
   chd_back #(.NUM_SYMBOLS(NUM_SYMBOLS), .MAX_CODE_LEN(MAX_CODE_LEN)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_symbol      (rsp_symbol),
      .rsp_end_of_data (rsp_end_of_data),
      .rsp_code_error  (rsp_code_error),
      .rsp_last        (rsp_last)
   );

endmodule

/* sv/chd_checker.sv */
// ----------------------------------------------------------------------------
// chd_checker
// Port-level checks on the decoder results.
// ----------------------------------------------------------------------------
module chd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic [7:0] rsp_symbol,
   input logic       rsp_end_of_data,
   input logic       rsp_code_error,
   input logic       rsp_last
);

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_end_of_data && rsp_code_error))
      else $error("end and error together");

   a_stop_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_end_of_data || rsp_code_error) |-> rsp_last)
      else $error("stop result not last of byte");

   a_stop_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_end_of_data || rsp_code_error) |-> rsp_symbol == 8'd0)
      else $error("stop result carries a symbol");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

endmodule

bind canonical_huffman_decoder chd_checker u_chd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_symbol      (rsp_symbol),
   .rsp_end_of_data (rsp_end_of_data),
   .rsp_code_error  (rsp_code_error),
   .rsp_last        (rsp_last)
);
